[hdl/skrt_pkg.sv]
`default_nettype none

package skrt_pkg;

    localparam int unsigned KEY_W           = 17;
    localparam int unsigned PAYLOAD_W       = 32;
    localparam int unsigned MAXE_W          = 4;
    localparam int unsigned CAPACITY_DEF    = 8;
    localparam int unsigned KEY_MIN_DEF     = 10000;
    localparam int unsigned KEY_LIMIT_DEF   = 100000;
    localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 4'd5;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_DELETE    = 2'd1,
        OP_LIST_ASC  = 2'd2,
        OP_LIST_DESC = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_RANGE    = 3'd5,
        ST_ENTRY    = 3'd6
    } t_status;

    typedef struct packed {
        t_op                  op;
        logic                 key_ok;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } t_cmd;

    typedef struct packed {
        t_status              status;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
    } t_result;

endpackage

`default_nettype wire

[hdl/skrt_fifo.sv]
`default_nettype none

module skrt_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr_ptr, n_wr_ptr;
    logic [AW:0]      r_rd_ptr, n_rd_ptr;
    logic             wr_en, rd_en;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]) && (r_wr_ptr[AW] != r_rd_ptr[AW]);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr[AW-1:0]];

    always_comb begin
        n_wr_ptr = wr_en ? (r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = rd_en ? (r_rd_ptr + 1'b1) : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

[hdl/skrt_front.sv]
`default_nettype none

module skrt_front
    import skrt_pkg::*;
#(
    parameter int unsigned KEY_MIN   = KEY_MIN_DEF,
    parameter int unsigned KEY_LIMIT = KEY_LIMIT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [KEY_W-1:0]     i_key,
    input  wire logic [PAYLOAD_W-1:0] i_payload,
    input  wire logic                 i_pop,
    output t_cmd                      o_cmd,
    output logic                      o_empty
);

    t_cmd             cmd;
    logic [31:0]      key_x;
    logic [$bits(t_cmd)-1:0] rdata;

    always_comb begin
        key_x       = 32'(i_key);
        cmd.op      = t_op'(i_req_type);
        cmd.key_ok  = (key_x >= 32'(KEY_MIN)) && (key_x < 32'(KEY_LIMIT));
        cmd.key     = i_key;
        cmd.payload = i_payload;
    end

    skrt_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (cmd),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_rdata (rdata),
        .o_empty (o_empty)
    );

    assign o_cmd = t_cmd'(rdata);

endmodule

`default_nettype wire

[hdl/skrt_back.sv]
`default_nettype none

module skrt_back
    import skrt_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_empty,
    input  wire t_cmd              i_cmd,
    output logic                   o_cmd_pop,
    input  wire logic [MAXE_W-1:0] i_max_entries,
    input  wire logic              i_res_full,
    output logic                   o_res_push,
    output t_result                o_res
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned MW = (CW > MAXE_W) ? CW : MAXE_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    logic [KEY_W-1:0]     mem_key [CAPACITY];
    logic [PAYLOAD_W-1:0] mem_pay [CAPACITY];

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [CAPACITY-1:0]  r_valid, n_valid;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_cmp_valid;
    logic [AW-1:0]        r_cmp_idx;
    logic [KEY_W-1:0]     r_rd_key;
    logic [PAYLOAD_W-1:0] r_rd_pay;
    logic                 r_hit, n_hit;
    logic [AW-1:0]        r_hit_idx, n_hit_idx;
    logic                 r_free_found, n_free_found;
    logic [AW-1:0]        r_free_idx, n_free_idx;
    logic                 r_best_found, n_best_found;
    logic [KEY_W-1:0]     r_best_key, n_best_key;
    logic [PAYLOAD_W-1:0] r_best_pay, n_best_pay;
    logic                 r_have_prev, n_have_prev;
    logic [KEY_W-1:0]     r_prev_key, n_prev_key;
    logic [CW-1:0]        r_emit_cnt, n_emit_cnt;
    t_result              r_res, n_res;
    logic                 r_more, n_more;

    logic                 tbl_full;
    logic                 scan_done;
    logic                 desc;
    logic                 slot_v;
    logic                 above_prev, better;
    logic                 mem_we;

    assign tbl_full  = (r_count == CW'(CAPACITY)) || (MW'(r_count) >= MW'(i_max_entries));
    assign scan_done = (r_idx == CW'(CAPACITY)) && !r_cmp_valid;
    assign desc      = (r_cmd.op == OP_LIST_DESC);
    assign slot_v    = r_valid[r_cmp_idx];

    always_comb begin
        above_prev = !r_have_prev || (desc ? (r_rd_key < r_prev_key) : (r_rd_key > r_prev_key));
        better     = !r_best_found || (desc ? (r_rd_key > r_best_key) : (r_rd_key < r_best_key));
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_valid      = r_valid;
        n_count      = r_count;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_best_found = r_best_found;
        n_best_key   = r_best_key;
        n_best_pay   = r_best_pay;
        n_have_prev  = r_have_prev;
        n_prev_key   = r_prev_key;
        n_emit_cnt   = r_emit_cnt;
        n_res        = r_res;
        n_more       = r_more;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        mem_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop    = 1'b1;
                    n_cmd        = i_cmd;
                    n_res.key    = '0;
                    n_res.payload = '0;
                    n_res.last   = 1'b1;
                    n_more       = 1'b0;
                    n_idx        = '0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_best_found = 1'b0;
                    n_have_prev  = 1'b0;
                    n_emit_cnt   = '0;
                    n_state      = S_SCAN;
                    case (i_cmd.op)
                        OP_INSERT: begin
                            if (tbl_full) begin
                                n_res.status = ST_FULL;
                                n_state      = S_EMIT;
                            end else if (!i_cmd.key_ok) begin
                                n_res.status = ST_RANGE;
                                n_state      = S_EMIT;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                                n_state      = S_EMIT;
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_idx != CW'(CAPACITY)) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_cmp_valid) begin
                    if (slot_v && (r_rd_key == r_cmd.key)) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_cmp_idx;
                    end
                    if (!slot_v && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_cmp_idx;
                    end
                    if (slot_v && above_prev && better) begin
                        n_best_found = 1'b1;
                        n_best_key   = r_rd_key;
                        n_best_pay   = r_rd_pay;
                    end
                end
                if (scan_done) begin
                    n_state       = S_EMIT;
                    n_res.key     = '0;
                    n_res.payload = '0;
                    n_res.last    = 1'b1;
                    n_more        = 1'b0;
                    case (r_cmd.op)
                        OP_INSERT: begin
                            if (r_hit) begin
                                n_res.status = ST_DUP;
                            end else if (!r_free_found) begin
                                n_res.status = ST_FULL;
                            end else begin
                                mem_we              = 1'b1;
                                n_valid[r_free_idx] = 1'b1;
                                n_count             = r_count + 1'b1;
                                n_res.status        = ST_DONE;
                            end
                        end
                        OP_DELETE: begin
                            if (r_hit) begin
                                n_valid[r_hit_idx] = 1'b0;
                                n_count            = r_count - 1'b1;
                                n_res.status       = ST_DONE;
                            end else begin
                                n_res.status = ST_NOTFOUND;
                            end
                        end
                        default: begin
                            n_res.status  = ST_ENTRY;
                            n_res.key     = r_best_key;
                            n_res.payload = r_best_pay;
                            n_res.last    = (CW'(r_emit_cnt + 1'b1) == r_count);
                            n_more        = !n_res.last;
                            n_prev_key    = r_best_key;
                            n_have_prev   = 1'b1;
                            n_emit_cnt    = r_emit_cnt + 1'b1;
                        end
                    endcase
                end
            end

            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_more) begin
                        n_state      = S_SCAN;
                        n_idx        = '0;
                        n_hit        = 1'b0;
                        n_free_found = 1'b0;
                        n_best_found = 1'b0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_cmp_valid <= (r_state == S_SCAN) && (r_idx != CW'(CAPACITY));
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_cmp_idx    <= r_idx[AW-1:0];
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_best_found <= n_best_found;
        r_best_key   <= n_best_key;
        r_best_pay   <= n_best_pay;
        r_have_prev  <= n_have_prev;
        r_prev_key   <= n_prev_key;
        r_emit_cnt   <= n_emit_cnt;
        r_res        <= n_res;
        r_more       <= n_more;
    end

    // key/payload store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_key[r_free_idx] <= r_cmd.key;
            mem_pay[r_free_idx] <= r_cmd.payload;
        end
        r_rd_key <= mem_key[r_idx[AW-1:0]];
        r_rd_pay <= mem_pay[r_idx[AW-1:0]];
    end

endmodule

`default_nettype wire

[hdl/sorted_key_record_table.sv]
// Insert/delete: 1 word each; full or out-of-range inserts and empty-table requests
//   skip the table scan, others scan every slot before answering.
// List: one word per stored record, each from its own selection scan of every slot.
//   Rate is set by the single-port slot scan and by result-queue back-pressure.
// Reset (synchronous, active low) empties the table and sets max_entries to 5;
//   both word queues are flushed.
`default_nettype none

module sorted_key_record_table
    import skrt_pkg::*;
#(
    parameter int unsigned CAPACITY  = CAPACITY_DEF,
    parameter int unsigned KEY_MIN   = KEY_MIN_DEF,
    parameter int unsigned KEY_LIMIT = KEY_LIMIT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [KEY_W-1:0]     i_key,
    input  wire logic [PAYLOAD_W-1:0] i_payload,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [2:0]                o_status,
    output logic [KEY_W-1:0]          o_out_key,
    output logic [PAYLOAD_W-1:0]      o_out_payload,
    output logic                      o_last,
    input  wire logic                 i_cfg_we,
    input  wire logic [MAXE_W-1:0]    i_cfg_wdata
);

    logic [MAXE_W-1:0]          r_max_entries;
    t_cmd                       cmd;
    logic                       cmd_empty, cmd_pop;
    t_result                    res_in;
    logic                       res_push, res_full;
    logic [$bits(t_result)-1:0] res_rdata;
    t_result                    res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_wdata;
        end
    end

    skrt_front #(
        .KEY_MIN   (KEY_MIN),
        .KEY_LIMIT (KEY_LIMIT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_req_type (i_req_type),
        .i_key      (i_key),
        .i_payload  (i_payload),
        .i_pop      (cmd_pop),
        .o_cmd      (cmd),
        .o_empty    (cmd_empty)
    );

    skrt_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_empty   (cmd_empty),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .i_max_entries (r_max_entries),
        .i_res_full    (res_full),
        .o_res_push    (res_push),
        .o_res         (res_in)
    );

    skrt_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_empty (empty)
    );

    assign res_out       = t_result'(res_rdata);
    assign o_status      = res_out.status;
    assign o_out_key     = res_out.key;
    assign o_out_payload = res_out.payload;
    assign o_last        = res_out.last;

endmodule

`default_nettype wire
